@@ hdl/pwmpd_pkg.sv @@
// Package for the percent-duty PWM generator.
// Holds the opcode type, the pipeline stage record and the fixed constants.
// Depends on nothing; every other file of the block depends on it.
package pwmpd_pkg;

  // Widths fixed by the item fields and the period register.
  localparam int unsigned PERIOD_W = 16;
  localparam int unsigned REQ_W    = 8;
  localparam int unsigned DUTY_W   = 7;
  localparam int unsigned PROD_W   = PERIOD_W + DUTY_W;

  // Item opcodes.
  typedef enum logic [0:0] {
    OP_TICK     = 1'b0,
    OP_SET_DUTY = 1'b1
  } opcode_t;

  // Duty limits in percent.
  localparam logic [DUTY_W-1:0] DUTY_OFF  = 7'd0;
  localparam logic [DUTY_W-1:0] DUTY_FULL = 7'd100;

  // Period limits and reset value.
  localparam logic [PERIOD_W-1:0] PERIOD_MIN   = 16'd2;
  localparam logic [PERIOD_W-1:0] PERIOD_RESET = 16'd1000;

  // Rounded division by 100: (x + 50) * RECIP_MULT >> RECIP_SHIFT is exact
  // for every x below 2**23.
  localparam logic [PROD_W-1:0] ROUND_BIAS  = 23'd50;
  localparam int unsigned       RECIP_W     = 24;
  localparam logic [RECIP_W-1:0] RECIP_MULT = 24'd10737419;
  localparam int unsigned       RECIP_SHIFT = 30;

  // Contents of the input stage register.
  typedef struct packed {
    opcode_t             op;
    logic [DUTY_W-1:0]   duty;
    logic [PROD_W-1:0]   prod;
  } stage_t;

endpackage

@@ hdl/pwmpd_cmd_if.sv @@
// Command channel of the percent-duty PWM generator: valid/ready plus payload.
// Depends on pwmpd_pkg for the opcode type.
interface pwmpd_cmd_if;
  logic                                   valid;
  logic                                   ready;
  pwmpd_pkg::opcode_t                     opcode;
  logic [pwmpd_pkg::REQ_W-1:0]            duty_request;

  modport source (output valid, output opcode, output duty_request, input ready);
  modport sink   (input valid, input opcode, input duty_request, output ready);
endinterface

@@ hdl/pwmpd_status_if.sv @@
// Status channel of the percent-duty PWM generator: valid/ready plus payload.
// Depends on pwmpd_pkg for the duty width.
interface pwmpd_status_if;
  logic                                   valid;
  logic                                   ready;
  logic                                   pin_level;
  logic                                   running;
  logic [pwmpd_pkg::DUTY_W-1:0]           duty_level;

  modport source (output valid, output pin_level, output running, output duty_level,
                  input ready);
  modport sink   (input valid, input pin_level, input running, input duty_level,
                  output ready);
endinterface

@@ hdl/pwm_generator_percent_duty.sv @@
// Top level of the percent-duty PWM generator.
// Depends on pwmpd_pkg, pwmpd_cmd_if, pwmpd_status_if and pwmpd_scale.
//
// Usage:
//   Commands arrive on the cmd channel: opcode OP_TICK is one time-base tick,
//   OP_SET_DUTY applies duty_request (percent, saturated to 100). Every
//   command gives exactly one status transfer on the status channel with the
//   pin level, the running flag and the applied duty, taken after the
//   command has been applied.
//   The PWM period in ticks is written through cfg_we/cfg_wdata; values
//   below 2 act as 2. Write it only while no command is in flight.
//   A command transferred at a clock edge enters the input stage register at
//   that edge, and its status enters the status register as it leaves the
//   stage, so the status transfer comes after both registers at earliest.
//   Throughput: one command per cycle while the status receiver keeps up;
//   the period-by-duty multiply sits before the input stage register and the
//   divide by 100 and the phase counter update sit between the two registers.
//   Reset (rst, synchronous) stops the generator with the output low, duty 0
//   and the period at 1000 ticks; no status is pending after reset.
//   A stalled status receiver holds the status register; the input stage
//   keeps taking commands until it too is full, then cmd.ready falls.
module pwm_generator_percent_duty #(
  parameter int unsigned COUNT_WIDTH = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [pwmpd_pkg::PERIOD_W-1:0] cfg_wdata,
  pwmpd_cmd_if.sink                      cmd,
  pwmpd_status_if.source                 status
);
  import pwmpd_pkg::*;

  localparam logic [32:0] CountMax = (33'd1 << COUNT_WIDTH) - 33'd1;

  // Configuration and derived period.
  logic [PERIOD_W-1:0] period_counts;
  logic [PERIOD_W-1:0] period_eff;

  // Input stage.
  logic                stage_valid;
  stage_t              stage;
  stage_t              stage_next;
  logic [DUTY_W-1:0]   duty_sat;
  logic                stage_fire;
  logic                status_free;

  // Generator state.
  logic [COUNT_WIDTH-1:0] tick_count, tick_count_next;
  logic [COUNT_WIDTH-1:0] phase_length, phase_length_next;
  logic [COUNT_WIDTH-1:0] high_count, high_count_next;
  logic [COUNT_WIDTH-1:0] low_count, low_count_next;
  logic                   phase_is_high, phase_is_high_next;
  logic                   is_running, is_running_next;
  logic [DUTY_W-1:0]      duty_now, duty_now_next;

  // Arithmetic helpers.
  logic [PERIOD_W-1:0]    high_len;
  logic [31:0]            high_wide;
  logic [31:0]            low_wide;
  logic [COUNT_WIDTH-1:0] tick_inc;

  // Period register.
  always_ff @(posedge clk) begin
    if (rst) begin
      period_counts <= PERIOD_RESET;
    end else if (cfg_we) begin
      period_counts <= cfg_wdata;
    end
  end

  // Period limited to at least two ticks and to the counter range.
  always_comb begin
    period_eff = period_counts;
    if (period_counts < PERIOD_MIN) begin
      period_eff = PERIOD_MIN;
    end
    if ({17'd0, period_counts} > CountMax) begin
      period_eff = CountMax[PERIOD_W-1:0];
    end
  end

  // Handshake: the status register frees when empty or being taken.
  assign status_free = !status.valid || status.ready;
  assign stage_fire  = stage_valid && status_free;
  assign cmd.ready   = !stage_valid || status_free;

  // Saturate the request and form the period-by-duty product.
  always_comb begin
    duty_sat = cmd.duty_request[DUTY_W-1:0];
    if (cmd.duty_request > {1'b0, DUTY_FULL}) begin
      duty_sat = DUTY_FULL;
    end
    stage_next.op   = cmd.opcode;
    stage_next.duty = duty_sat;
    stage_next.prod = {{DUTY_W{1'b0}}, period_eff} * {{PERIOD_W{1'b0}}, duty_sat};
  end

  // Input stage register.
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (cmd.ready) begin
      stage_valid <= cmd.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ready && cmd.valid) begin
      stage <= stage_next;
    end
  end

  // High-phase count from the product.
  pwmpd_scale u_scale (
    .prod     (stage.prod),
    .period   (period_eff),
    .high_len (high_len)
  );

  assign high_wide = {16'd0, high_len};
  assign low_wide  = {16'd0, period_eff - high_len};
  assign tick_inc  = tick_count + {{(COUNT_WIDTH-1){1'b0}}, 1'b1};

  // Next generator state for the command in the input stage.
  always_comb begin
    tick_count_next    = tick_count;
    phase_length_next  = phase_length;
    high_count_next    = high_count;
    low_count_next     = low_count;
    phase_is_high_next = phase_is_high;
    is_running_next    = is_running;
    duty_now_next      = duty_now;
    case (stage.op)
      OP_TICK: begin
        if (is_running) begin
          if (tick_inc >= phase_length) begin
            tick_count_next    = '0;
            phase_is_high_next = !phase_is_high;
            phase_length_next  = phase_is_high ? low_count : high_count;
          end else begin
            tick_count_next = tick_inc;
          end
        end
      end
      OP_SET_DUTY: begin
        if (stage.duty == DUTY_OFF) begin
          is_running_next    = 1'b0;
          phase_is_high_next = 1'b0;
          duty_now_next      = DUTY_OFF;
        end else if (stage.duty == DUTY_FULL) begin
          is_running_next    = 1'b0;
          phase_is_high_next = 1'b1;
          duty_now_next      = DUTY_FULL;
        end else begin
          high_count_next = high_wide[COUNT_WIDTH-1:0];
          low_count_next  = low_wide[COUNT_WIDTH-1:0];
          duty_now_next   = stage.duty;
          if (!is_running) begin
            phase_is_high_next = 1'b1;
            tick_count_next    = '0;
            phase_length_next  = high_wide[COUNT_WIDTH-1:0];
            is_running_next    = 1'b1;
          end
        end
      end
      default: begin
        tick_count_next = tick_count;
      end
    endcase
  end

  // Generator state registers, updated as each command leaves the stage.
  always_ff @(posedge clk) begin
    if (rst) begin
      tick_count    <= '0;
      phase_length  <= '0;
      high_count    <= '0;
      low_count     <= COUNT_WIDTH'(PERIOD_RESET);
      phase_is_high <= 1'b0;
      is_running    <= 1'b0;
      duty_now      <= DUTY_OFF;
    end else if (stage_fire) begin
      tick_count    <= tick_count_next;
      phase_length  <= phase_length_next;
      high_count    <= high_count_next;
      low_count     <= low_count_next;
      phase_is_high <= phase_is_high_next;
      is_running    <= is_running_next;
      duty_now      <= duty_now_next;
    end
  end

  // Status register.
  always_ff @(posedge clk) begin
    if (rst) begin
      status.valid <= 1'b0;
    end else if (status_free) begin
      status.valid <= stage_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (stage_fire) begin
      status.pin_level  <= phase_is_high_next;
      status.running    <= is_running_next;
      status.duty_level <= duty_now_next;
    end
  end

endmodule

@@ hdl/pwmpd_scale.sv @@
// High-phase count from the registered period-by-duty product.
// Rounded division by 100 through a reciprocal multiply, then clamping.
// Depends on pwmpd_pkg.
module pwmpd_scale (
  input  logic [pwmpd_pkg::PROD_W-1:0]   prod,
  input  logic [pwmpd_pkg::PERIOD_W-1:0] period,
  output logic [pwmpd_pkg::PERIOD_W-1:0] high_len
);
  import pwmpd_pkg::*;

  localparam int unsigned MUL_W = PROD_W + RECIP_W;

  logic [PROD_W-1:0]   biased;
  logic [MUL_W-1:0]    scaled;
  logic [PERIOD_W-1:0] quot;
  logic [PERIOD_W-1:0] top_len;

  // Add half the divisor, then multiply by the reciprocal of 100.
  assign biased = prod + ROUND_BIAS;
  assign scaled = {{RECIP_W{1'b0}}, biased} * {{PROD_W{1'b0}}, RECIP_MULT};
  assign quot   = scaled[RECIP_SHIFT +: PERIOD_W];
  assign top_len = period - 16'd1;

  // Keep at least one tick in each phase.
  always_comb begin
    high_len = quot;
    if (quot == '0) begin
      high_len = 16'd1;
    end
    if (quot > top_len) begin
      high_len = top_len;
    end
  end

endmodule

@@ hdl/pwmpd_checks.sv @@
// Port-level checks for the percent-duty PWM generator, bound to the top level.
// Depends on pwmpd_pkg and on the top-level port names.
module pwmpd_checks (
  input logic                         clk,
  input logic                         rst,
  input logic                         st_valid,
  input logic                         st_ready,
  input logic                         pin_level,
  input logic                         running,
  input logic [pwmpd_pkg::DUTY_W-1:0] duty_level
);
  import pwmpd_pkg::*;

  // A stalled status transfer keeps its contents.
  a_status_hold: assert property (@(posedge clk) disable iff (rst)
    st_valid && !st_ready |=> st_valid && $stable(pin_level) && $stable(running)
      && $stable(duty_level))
    else $error("status changed while stalled");

  // Applied duty never exceeds full scale.
  a_duty_range: assert property (@(posedge clk) disable iff (rst)
    st_valid |-> duty_level <= DUTY_FULL)
    else $error("duty above 100 percent");

  // Switching only happens at a duty strictly between off and full.
  a_running_duty: assert property (@(posedge clk) disable iff (rst)
    st_valid && running |-> duty_level != DUTY_OFF && duty_level != DUTY_FULL)
    else $error("running at duty 0 or 100");

  // Duty 0 means stopped and low.
  a_off_low: assert property (@(posedge clk) disable iff (rst)
    st_valid && duty_level == DUTY_OFF |-> !pin_level && !running)
    else $error("duty 0 but output not stopped low");

  // Duty 100 means stopped and high.
  a_full_high: assert property (@(posedge clk) disable iff (rst)
    st_valid && duty_level == DUTY_FULL |-> pin_level && !running)
    else $error("duty 100 but output not held high");

endmodule

bind pwm_generator_percent_duty pwmpd_checks u_pwmpd_checks (
  .clk        (clk),
  .rst        (rst),
  .st_valid   (status.valid),
  .st_ready   (status.ready),
  .pin_level  (status.pin_level),
  .running    (status.running),
  .duty_level (status.duty_level)
);
